### src/gfc_pkg.sv
`default_nettype none
package gfc_pkg;

  localparam int MaxCanvasWidth  = 256;
  localparam int MaxCanvasHeight = 256;
  localparam int PaletteEntries  = 256;

  localparam logic [8:0] CanvasWidthReset  = 9'd256;
  localparam logic [8:0] CanvasHeightReset = 9'd256;

  // function codes
  localparam logic [2:0] FUNC_LOAD    = 3'd0;
  localparam logic [2:0] FUNC_BEGIN   = 3'd1;
  localparam logic [2:0] FUNC_PIXEL   = 3'd2;
  localparam logic [2:0] FUNC_READ    = 3'd3;
  localparam logic [2:0] FUNC_DISPOSE = 3'd4;

  // disposal modes
  localparam logic [2:0] DISP_CLEAR   = 3'd2;
  localparam logic [2:0] DISP_RESTORE = 3'd3;

  // configuration register indexes
  localparam logic [0:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'd1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_BACKUP_RD,
    ST_BACKUP_WR,
    ST_RESTORE_RD,
    ST_RESTORE_WR,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic exec;
    logic read_issue;
    logic read_load;
    logic sweep_start;
    logic sweep_step;
    logic init_wr;
    logic backup_rd;
    logic backup_wr;
    logic restore_rd;
    logic restore_wr;
    logic clear_wr;
    logic out_load;
  } gfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic [2:0] dispose_mode;
    logic       sweep_last;
    logic       clear_empty;
  } gfc_stat_t;

endpackage
`default_nettype wire

### src/gfc_ctrl.sv
`default_nettype none
module gfc_ctrl
  import gfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire logic      m_tready,
  output logic           m_tvalid,
  input  wire gfc_stat_t stat,
  output gfc_cmd_t       cmd
);

  state_t state, state_next;
  logic   out_full;

  // state register and output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_full <= 1'b1;
      else if (m_tready) out_full <= 1'b0;
    end
  end

  assign m_tvalid = out_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (stat.sweep_last) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (stat.func)
          FUNC_READ: state_next = ST_READ;
          FUNC_BEGIN:
            state_next = (stat.dispose_mode == DISP_RESTORE) ? ST_BACKUP_RD : ST_OUT;
          FUNC_DISPOSE: begin
            if (stat.dispose_mode == DISP_RESTORE) state_next = ST_RESTORE_RD;
            else if (stat.dispose_mode == DISP_CLEAR && !stat.clear_empty)
              state_next = ST_CLEAR;
            else state_next = ST_OUT;
          end
          default: state_next = ST_OUT;
        endcase
      end
      ST_READ:       state_next = ST_OUT;
      ST_BACKUP_RD:  state_next = ST_BACKUP_WR;
      ST_BACKUP_WR:  state_next = stat.sweep_last ? ST_OUT : ST_BACKUP_RD;
      ST_RESTORE_RD: state_next = ST_RESTORE_WR;
      ST_RESTORE_WR: state_next = stat.sweep_last ? ST_OUT : ST_RESTORE_RD;
      ST_CLEAR:      if (stat.sweep_last) state_next = ST_OUT;
      ST_OUT:        if (!out_full || m_tready) state_next = ST_IDLE;
      default:       state_next = ST_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_INIT: cmd.init_wr = 1'b1;
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take_item = s_tvalid;
        cmd.sweep_start = s_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.read_issue = (stat.func == FUNC_READ);
      end
      ST_READ:       cmd.read_load = 1'b1;
      ST_BACKUP_RD:  cmd.backup_rd = 1'b1;
      ST_BACKUP_WR: begin
        cmd.backup_wr = 1'b1;
        cmd.sweep_step = 1'b1;
      end
      ST_RESTORE_RD: cmd.restore_rd = 1'b1;
      ST_RESTORE_WR: begin
        cmd.restore_wr = 1'b1;
        cmd.sweep_step = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.sweep_step = 1'b1;
      end
      ST_OUT:  cmd.out_load = !out_full || m_tready;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/gfc_datapath.sv
`default_nettype none
module gfc_datapath
  import gfc_pkg::*;
#(
  parameter int MAX_CANVAS_WIDTH  = MaxCanvasWidth,
  parameter int MAX_CANVAS_HEIGHT = MaxCanvasHeight,
  parameter int PALETTE_ENTRIES   = PaletteEntries
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [127:0] s_tdata,
  input  wire logic         cfg_valid,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [8:0]   cfg_data,
  input  wire gfc_cmd_t     cmd,
  output gfc_stat_t         stat,
  output logic [39:0]       m_tdata
);

  localparam int XW = $clog2(MAX_CANVAS_WIDTH);
  localparam int YW = $clog2(MAX_CANVAS_HEIGHT);
  localparam int AW = XW + YW;
  localparam int Depth = 1 << AW;
  localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [12:0] MaxW = 13'(MAX_CANVAS_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_CANVAS_HEIGHT);

  logic [31:0] canvas [Depth];
  logic [31:0] backup [Depth];
  logic [23:0] palette [PALETTE_ENTRIES];

  // held item fields
  logic [2:0]  func;
  logic [7:0]  idx;
  logic [23:0] color;
  logic [8:0]  count;
  logic [15:0] in_left, in_top, in_fw, in_fh;
  logic [7:0]  trans;
  logic        has_t;
  logic [2:0]  disp;

  // frame state
  logic [CW-1:0] pal_count;
  logic [15:0] rect_left, rect_top, rect_width, rect_height;
  logic        key_valid;
  logic [7:0]  key_index;
  logic [2:0]  dispose_mode;
  logic [15:0] col_cnt, row_cnt;
  logic [8:0]  screen_width, screen_height;

  // sweep address and clear rectangle
  logic [AW:0]   sweep;
  logic [XW-1:0] cx_s, cx_lo, cx_hi;
  logic [YW-1:0] cy_s, cy_hi;
  logic [31:0]   xfer;
  logic [31:0]   rd_pix;
  logic          res_status;
  logic [31:0]   res_pix;

  // effective canvas size
  logic [12:0] eff_w, eff_h;
  always_comb begin
    eff_w = ({4'd0, screen_width} < MaxW) ? {4'd0, screen_width} : MaxW;
    eff_h = ({4'd0, screen_height} < MaxH) ? {4'd0, screen_height} : MaxH;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CanvasWidthReset;
      screen_height <= CanvasHeightReset;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SCREEN_WIDTH) screen_width <= cfg_data;
      else screen_height <= cfg_data;
    end
  end

  // pixel position and decisions
  logic [16:0] px, py;
  logic        pix_beyond, pix_write, pal_ok;
  logic [15:0] col_inc;
  always_comb begin
    px = {1'b0, rect_left} + {1'b0, col_cnt};
    py = {1'b0, rect_top} + {1'b0, row_cnt};
    pix_beyond = (rect_width == 16'd0) || (row_cnt >= rect_height);
    pal_ok = ({1'b0, idx} < 9'(PALETTE_ENTRIES)) && ({1'b0, idx} < 9'(pal_count));
    pix_write = !(key_valid && idx == key_index) && pal_ok
                && (px < {4'd0, eff_w}) && (py < {4'd0, eff_h});
    col_inc = col_cnt + 16'd1;
  end

  logic read_on;
  always_comb read_on = ({1'b0, in_left} < {4'd0, eff_w}) && ({1'b0, in_top} < {4'd0, eff_h});

  // clear rectangle end, clipped
  logic [16:0] xe, ye;
  always_comb begin
    xe = {1'b0, rect_left} + {1'b0, rect_width};
    ye = {1'b0, rect_top} + {1'b0, rect_height};
    if (xe > {4'd0, eff_w}) xe = {4'd0, eff_w};
    if (ye > {4'd0, eff_h}) ye = {4'd0, eff_h};
  end

  // begin decides on the mode it carries, dispose on the latched one
  assign stat.func = func;
  assign stat.dispose_mode = (func == FUNC_BEGIN) ? disp : dispose_mode;
  assign stat.clear_empty = ({1'b0, rect_left} >= xe) || ({1'b0, rect_top} >= ye);
  assign stat.sweep_last = cmd.clear_wr ? (cx_s == cx_hi && cy_s == cy_hi)
                                        : (sweep[AW-1:0] == AW'(Depth - 1));

  // item fields and frame state
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      func  <= s_tdata[2:0];
      idx   <= s_tdata[10:3];
      color <= s_tdata[34:11];
      count <= s_tdata[43:35];
      in_left <= s_tdata[59:44];
      in_top  <= s_tdata[75:60];
      in_fw   <= s_tdata[91:76];
      in_fh   <= s_tdata[107:92];
      trans   <= s_tdata[115:108];
      has_t   <= s_tdata[116];
      disp    <= s_tdata[119:117];
    end
    if (rst) begin
      pal_count <= '0;
      rect_left <= '0; rect_top <= '0; rect_width <= '0; rect_height <= '0;
      key_valid <= 1'b0; key_index <= '0;
      dispose_mode <= '0;
      col_cnt <= '0; row_cnt <= '0;
    end else if (cmd.exec) begin
      if (func == FUNC_BEGIN) begin
        pal_count <= ({1'b0, count} > 10'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES)
                                                            : CW'(count);
        rect_left <= in_left; rect_top <= in_top;
        rect_width <= in_fw; rect_height <= in_fh;
        key_valid <= has_t; key_index <= trans;
        dispose_mode <= disp;
        col_cnt <= '0; row_cnt <= '0;
      end else if (func == FUNC_PIXEL && !pix_beyond) begin
        if (col_inc >= rect_width) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 16'd1;
        end else col_cnt <= col_inc;
      end
    end
  end

  // sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.init_wr) begin
      sweep <= sweep + (AW+1)'(1);
    end else if (cmd.sweep_start) begin
      sweep <= '0;
    end else if (cmd.sweep_step) begin
      sweep <= sweep + (AW+1)'(1);
    end
    if (cmd.exec) begin
      cx_s  <= rect_left[XW-1:0];
      cx_lo <= rect_left[XW-1:0];
      cy_s  <= rect_top[YW-1:0];
      cx_hi <= XW'(xe - 17'd1);
      cy_hi <= YW'(ye - 17'd1);
    end else if (cmd.clear_wr) begin
      if (cx_s == cx_hi) begin
        cx_s <= cx_lo;
        cy_s <= cy_s + YW'(1);
      end else cx_s <= cx_s + XW'(1);
    end
  end

  // palette memory
  logic [23:0] pal_rd;
  always_ff @(posedge clk) begin
    if (cmd.exec && func == FUNC_LOAD && {1'b0, idx} < 9'(PALETTE_ENTRIES))
      palette[PW'(idx)] <= color;
    pal_rd <= palette[PW'(s_tdata[10:3])];
  end

  // canvas memory, one write port and one read port
  logic          cv_we;
  logic [AW-1:0] cv_wa, cv_ra;
  logic [31:0]   cv_wd;
  always_comb begin
    cv_we = 1'b0;
    cv_wa = sweep[AW-1:0];
    cv_wd = '0;
    cv_ra = sweep[AW-1:0];
    if (cmd.init_wr) cv_we = 1'b1;
    else if (cmd.exec && func == FUNC_PIXEL && !pix_beyond && pix_write) begin
      cv_we = 1'b1;
      cv_wa = {py[YW-1:0], px[XW-1:0]};
      cv_wd = {pal_rd, 8'hFF};
    end else if (cmd.restore_wr) begin
      cv_we = 1'b1;
      cv_wd = xfer;
    end else if (cmd.clear_wr) begin
      cv_we = 1'b1;
      cv_wa = {cy_s, cx_s};
    end
    if (cmd.read_issue) cv_ra = {in_top[YW-1:0], in_left[XW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cv_we) canvas[cv_wa] <= cv_wd;
    rd_pix <= canvas[cv_ra];
  end

  // backup memory
  logic [31:0] bk_rd;
  always_ff @(posedge clk) begin
    if (cmd.backup_wr) backup[sweep[AW-1:0]] <= rd_pix;
    bk_rd <= backup[sweep[AW-1:0]];
  end
  always_comb xfer = bk_rd;

  // result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_pix <= '0;
      res_status <= (func == FUNC_PIXEL && pix_beyond) || (func == FUNC_READ && !read_on);
    end else if (cmd.read_load && !res_status) begin
      res_pix <= rd_pix;
    end
    if (cmd.out_load) m_tdata <= {7'd0, res_status, res_pix[7:0], res_pix[15:8],
                                  res_pix[23:16], res_pix[31:24]};
  end

endmodule
`default_nettype wire

### src/gif_frame_compositor.sv
`default_nettype none
// channel   dir  handshake                data
// s_axis    in   s_tvalid/s_tready        s_tdata item fields
// m_axis    out  m_tvalid/m_tready        m_tdata result fields
// cfg       in   cfg_valid/cfg_ready      cfg_index, cfg_data
// one item at a time: palette load, pixel and keep-dispose go idle, exec, out; read adds a read state before out
// begin with restore mode and restore-dispose walk the whole canvas memory, a read state and a write state per entry
// clear-dispose writes one clipped rectangle pixel per cycle
// after reset the whole canvas memory is cleared one entry a cycle, no items taken
// a waiting result stalls only the next item's finish, held in an output register
module gif_frame_compositor
  import gfc_pkg::*;
#(
  parameter int MAX_CANVAS_WIDTH  = MaxCanvasWidth,
  parameter int MAX_CANVAS_HEIGHT = MaxCanvasHeight,
  parameter int PALETTE_ENTRIES   = PaletteEntries
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // func, index, color, color_count, left, top, frame_width, frame_height,
  // transparent, has_transparent, disposal, zero fill
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // red, green, blue, alpha, status, zero fill
  output logic [39:0]       m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [8:0]   cfg_data
);

  gfc_cmd_t  cmd;
  gfc_stat_t stat;

  assign cfg_ready = 1'b1;

  gfc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .stat(stat), .cmd(cmd)
  );

  gfc_datapath #(
    .MAX_CANVAS_WIDTH(MAX_CANVAS_WIDTH),
    .MAX_CANVAS_HEIGHT(MAX_CANVAS_HEIGHT),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
    .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire
